### sv/tpus_pkg.sv
package tpus_pkg;

    // field widths
    localparam int TEMP_W      = 15;
    localparam int TENTHS_W    = 14;
    localparam int SP_W        = 9;
    localparam int CFG_IDX_W   = 1;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 40;

    // reset values
    localparam logic signed [SP_W-1:0]     SP_MIN_RST = -9'sd80;
    localparam logic signed [SP_W-1:0]     SP_MAX_RST = 9'sd170;
    localparam logic signed [SP_W-1:0]     SP_RST     = 9'sd40;
    localparam logic signed [TEMP_W-1:0]   HELD_RST   = 15'sd2500;
    localparam logic signed [TENTHS_W-1:0] TEMP_T_RST = 14'sd0;
    localparam logic signed [TENTHS_W-1:0] TARG_T_RST = 14'sd200;

    typedef enum logic [1:0] {
        MODE_SHOW = 2'd0,
        MODE_SET  = 2'd1,
        MODE_UNIT = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        UNIT_C = 2'd0,
        UNIT_F = 2'd1,
        UNIT_K = 2'd2,
        UNIT_R = 2'd3
    } t_unit;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SP_MIN = 1'b0,
        CFG_SP_MAX = 1'b1
    } t_cfg_idx;

    // one input beat
    typedef struct packed {
        logic signed [TEMP_W-1:0] temp_sample;
        logic                     down_btn;
        logic                     up_btn;
        logic                     mode_btn;
    } t_in_beat;

    // state after one tick, handed to the conversion stage
    typedef struct packed {
        logic                     heater;
        t_mode                    mode;
        t_unit                    unit;
        logic signed [TEMP_W-1:0] held_temp;
        logic signed [SP_W-1:0]   setpoint;
        logic                     upd_temp;
        logic                     upd_target;
    } t_ctrl_res;

endpackage

### sv/tpus_ctrl.sv
module tpus_ctrl import tpus_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_move,
    input  t_in_beat              i_beat,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [SP_W-1:0]       i_cfg_data,
    output t_ctrl_res             o_res
);

    t_mode                    r_mode, n_mode;
    t_unit                    r_unit, n_unit;
    logic signed [SP_W-1:0]   r_sp, n_sp;
    logic signed [SP_W-1:0]   r_sp_min, r_sp_max;
    logic signed [TEMP_W-1:0] r_held, n_held;
    logic                     r_prev_mode, r_prev_up, r_prev_down;
    logic                     n_prev_up, n_prev_down;
    t_ctrl_res                r_res, n_res;

    logic                     w_mode_edge, w_up_edge, w_dn_edge;
    logic signed [SP_W-1:0]   w_sp_up;
    t_unit                    w_unit_up;
    logic signed [15:0]       w_sp16, w_sp50, w_held16;

    assign w_mode_edge = i_beat.mode_btn & ~r_prev_mode;
    assign w_up_edge   = i_beat.up_btn   & ~r_prev_up;
    assign w_dn_edge   = i_beat.down_btn & ~r_prev_down;

    // panel mode: next state
    always_comb begin
        n_mode = r_mode;
        if (w_mode_edge) begin
            unique case (r_mode)
                MODE_SHOW: n_mode = MODE_SET;
                MODE_SET:  n_mode = MODE_UNIT;
                MODE_UNIT: n_mode = MODE_SHOW;
                default:   n_mode = MODE_SHOW;
            endcase
        end
    end

    // action of the new mode
    always_comb begin
        n_sp        = r_sp;
        n_unit      = r_unit;
        n_held      = r_held;
        n_prev_up   = r_prev_up;
        n_prev_down = r_prev_down;
        w_sp_up     = r_sp;
        w_unit_up   = r_unit;
        n_res       = '0;
        unique case (n_mode)
            MODE_SHOW: begin
                n_held          = i_beat.temp_sample;
                n_res.upd_temp  = 1'b1;
            end
            MODE_SET: begin
                // up first, then down, each only while inside the bounds
                w_sp_up = (w_up_edge && (r_sp < r_sp_max)) ? r_sp + 9'sd1 : r_sp;
                n_sp    = (w_dn_edge && (w_sp_up > r_sp_min)) ? w_sp_up - 9'sd1 : w_sp_up;
            end
            MODE_UNIT: begin
                w_unit_up = w_up_edge ? t_unit'(r_unit + 2'd1) : r_unit;
                n_unit    = w_dn_edge ? t_unit'(w_unit_up - 2'd1) : w_unit_up;
            end
            default: begin
                n_held = r_held;
            end
        endcase
        if (n_mode != MODE_SHOW) begin
            n_prev_up        = i_beat.up_btn;
            n_prev_down      = i_beat.down_btn;
            n_res.upd_target = i_beat.up_btn | i_beat.down_btn;
        end
        n_res.mode      = n_mode;
        n_res.unit      = n_unit;
        n_res.held_temp = n_held;
        n_res.setpoint  = n_sp;
        n_res.heater    = w_held16 < w_sp50;
    end

    // heater compare in hundredths: setpoint * 50 by shift and add
    assign w_sp16   = {{(16-SP_W){n_sp[SP_W-1]}}, n_sp};
    assign w_sp50   = (w_sp16 <<< 5) + (w_sp16 <<< 4) + (w_sp16 <<< 1);
    assign w_held16 = {{(16-TEMP_W){n_held[TEMP_W-1]}}, n_held};

    // state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_SHOW;
            r_unit      <= UNIT_C;
            r_sp        <= SP_RST;
            r_held      <= HELD_RST;
            r_prev_mode <= 1'b0;
            r_prev_up   <= 1'b0;
            r_prev_down <= 1'b0;
            r_sp_min    <= SP_MIN_RST;
            r_sp_max    <= SP_MAX_RST;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_SP_MIN: r_sp_min <= i_cfg_data;
                    CFG_SP_MAX: r_sp_max <= i_cfg_data;
                endcase
            end
            if (i_move) begin
                r_mode      <= n_mode;
                r_unit      <= n_unit;
                r_sp        <= n_sp;
                r_held      <= n_held;
                r_prev_mode <= i_beat.mode_btn;
                r_prev_up   <= n_prev_up;
                r_prev_down <= n_prev_down;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res <= '0;
        end else if (i_move) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

`ifndef SYNTHESIS
    a_state_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && !$past(i_move) |-> $stable(r_sp) && $stable(r_mode) && $stable(r_unit))
        else $error("panel state changed without a beat");

    a_sp_in_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && (r_sp != $past(r_sp)) |-> (r_mode == MODE_SET))
        else $error("setpoint moved outside set mode");

    a_unit_in_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && (r_unit != $past(r_unit)) |-> (r_mode == MODE_UNIT))
        else $error("unit changed outside unit mode");
`endif

endmodule

### sv/tpus_conv.sv
module tpus_conv import tpus_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_move,
    input  t_ctrl_res                  i_res,
    output logic                       o_heater,
    output t_mode                      o_mode,
    output t_unit                      o_unit,
    output logic signed [TENTHS_W-1:0] o_temp_tenths,
    output logic signed [TENTHS_W-1:0] o_target_tenths
);

    // reciprocals: floor(x/10) = (x*RECIP10) >> 23, floor(x/50) = (x*RECIP50) >> 25
    localparam logic [19:0] RECIP10 = 20'd838861;
    localparam logic [19:0] RECIP50 = 20'd671089;
    localparam int          SH10    = 23;
    localparam int          SH50    = 25;

    logic                       r_heater;
    t_mode                      r_mode;
    t_unit                      r_unit;
    logic signed [TENTHS_W-1:0] r_temp_tenths, r_target_tenths;

    logic signed [19:0]         w_h20, w_h9, w_num;
    logic                       w_d50, w_neg;
    logic [19:0]                w_mag, w_rnd, w_recip;
    logic [39:0]                w_prod;
    logic [TENTHS_W-1:0]        w_q;
    logic signed [TENTHS_W-1:0] w_temp;
    logic signed [TENTHS_W-1:0] w_s14, w_s5, w_s9, w_target;

    // sample in hundredths C to numerator over 10 or 50
    assign w_h20 = {{(20-TEMP_W){i_res.held_temp[TEMP_W-1]}}, i_res.held_temp};
    assign w_h9  = (w_h20 <<< 3) + w_h20;

    always_comb begin
        unique case (i_res.unit)
            UNIT_C: begin w_num = w_h20;                w_d50 = 1'b0; end
            UNIT_F: begin w_num = w_h9 + 20'sd16000;    w_d50 = 1'b1; end
            UNIT_K: begin w_num = w_h20 + 20'sd27315;   w_d50 = 1'b0; end
            UNIT_R: begin w_num = w_h9 + 20'sd245835;   w_d50 = 1'b1; end
        endcase
    end

    // divide magnitude with rounding half away from zero, then restore sign
    assign w_neg   = w_num[19];
    assign w_mag   = w_neg ? 20'(-w_num) : 20'(w_num);
    assign w_rnd   = w_mag + (w_d50 ? 20'd25 : 20'd5);
    assign w_recip = w_d50 ? RECIP50 : RECIP10;
    assign w_prod  = w_rnd * w_recip;
    assign w_q     = w_d50 ? w_prod[SH50 +: TENTHS_W] : w_prod[SH10 +: TENTHS_W];
    assign w_temp  = w_neg ? -w_q : w_q;

    // setpoint in half degrees: every unit is exact up to a fixed offset
    assign w_s14 = {{(TENTHS_W-SP_W){i_res.setpoint[SP_W-1]}}, i_res.setpoint};
    assign w_s5  = (w_s14 <<< 2) + w_s14;
    assign w_s9  = (w_s14 <<< 3) + w_s14;

    always_comb begin
        unique case (i_res.unit)
            UNIT_C: w_target = w_s5;
            UNIT_F: w_target = w_s9 + 14'sd320;
            UNIT_K: w_target = w_s5 + 14'sd2732;
            UNIT_R: w_target = w_s9 + 14'sd4917;
        endcase
    end

    // result register; the tenths values persist between refreshes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heater        <= 1'b0;
            r_mode          <= MODE_SHOW;
            r_unit          <= UNIT_C;
            r_temp_tenths   <= TEMP_T_RST;
            r_target_tenths <= TARG_T_RST;
        end else if (i_move) begin
            r_heater <= i_res.heater;
            r_mode   <= i_res.mode;
            r_unit   <= i_res.unit;
            if (i_res.upd_temp) begin
                r_temp_tenths <= w_temp;
            end
            if (i_res.upd_target) begin
                r_target_tenths <= w_target;
            end
        end
    end

    assign o_heater        = r_heater;
    assign o_mode          = r_mode;
    assign o_unit          = r_unit;
    assign o_temp_tenths   = r_temp_tenths;
    assign o_target_tenths = r_target_tenths;

endmodule

### sv/thermostat_panel_with_unit_select_top.sv
// Path: a beat accepted at the input is registered in turn by the input register, the
// panel state update and the unit conversion before it is presented on the result port.
// Throughput: one beat per cycle; each stage holds while the next one is full, so the
// input is still taken while a result waits on the output, until all three stages hold.
// Reset: synchronous, active low; panel state, bounds and shown values return to their
// defaults at once, with no clearing pass.
module thermostat_panel_with_unit_select_top import tpus_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [0] mode_button, [1] up_button, [2] down_button, [17:3] temp_sample, [23:18] zero
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [0] heater_on, [2:1] panel_mode, [4:3] unit_sel, [18:5] shown_temp,
    // [32:19] shown_target, [39:33] zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [SP_W-1:0]        i_cfg_data
);

    t_in_beat                   r_in;
    logic                       r_a_vld, r_b_vld, r_c_vld;
    logic                       w_in_acc, w_a_move, w_b_move, w_b_rdy, w_c_rdy, w_out_acc;
    t_ctrl_res                  w_res;
    logic                       w_heater;
    t_mode                      w_mode;
    t_unit                      w_unit;
    logic signed [TENTHS_W-1:0] w_temp_tenths, w_target_tenths;

    // stage handshakes
    assign w_c_rdy       = !r_c_vld || m_axis_tready;
    assign w_b_move      = r_b_vld && w_c_rdy;
    assign w_b_rdy       = !r_b_vld || w_c_rdy;
    assign w_a_move      = r_a_vld && w_b_rdy;
    assign s_axis_tready = !r_a_vld || w_b_rdy;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_out_acc     = r_c_vld && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
        end else begin
            r_a_vld <= w_in_acc || (r_a_vld && !w_a_move);
            r_b_vld <= w_a_move || (r_b_vld && !w_b_move);
            r_c_vld <= w_b_move || (r_c_vld && !w_out_acc);
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in.mode_btn    <= s_axis_tdata[0];
            r_in.up_btn      <= s_axis_tdata[1];
            r_in.down_btn    <= s_axis_tdata[2];
            r_in.temp_sample <= s_axis_tdata[3 +: TEMP_W];
        end
    end

    tpus_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_move     (w_a_move),
        .i_beat     (r_in),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_res      (w_res)
    );

    tpus_conv u_conv (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_move          (w_b_move),
        .i_res           (w_res),
        .o_heater        (w_heater),
        .o_mode          (w_mode),
        .o_unit          (w_unit),
        .o_temp_tenths   (w_temp_tenths),
        .o_target_tenths (w_target_tenths)
    );

    // result beat
    assign m_axis_tvalid = r_c_vld;
    assign m_axis_tdata  = {7'b0, w_target_tenths, w_temp_tenths, w_unit, w_mode, w_heater};

`ifndef SYNTHESIS
    a_b_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(r_b_vld && !w_c_rdy) |-> r_b_vld)
        else $error("state stage dropped a beat while the output was full");

    a_c_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(w_b_move) |-> r_c_vld)
        else $error("converted beat did not reach the output register");

    a_a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_vld && !w_a_move |-> !s_axis_tready)
        else $error("input register open while holding a beat");
`endif

endmodule
